[src/cssoc_pkg.sv]
// Shared types and constants for the charge session SOC tracker.
package cssoc_pkg;

  localparam logic [7:0] NUM_CELLS = 8'd96;

  localparam logic       OP_FRAME = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [10:0] ID_MAX_CUR = 11'h108;
  localparam logic [10:0] ID_STATUS  = 11'h109;

  localparam logic [1:0] REG_USER_LIMIT = 2'd0;
  localparam logic [1:0] REG_CAPACITY   = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;

  localparam logic [13:0] SOC_FULL = 14'd10000;

  // Dividend is charge times ten, divisor is capacity times 36.
  localparam int DIVD_W = 36;
  localparam int DIVS_W = 16;
  localparam int CNT_W  = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

[src/cssoc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module cssoc_div import cssoc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVS_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W:0]   trial;
  logic              take;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIVD_W-2:0], take};
      rem      <= take ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
    end
  end

endmodule

[src/charge_session_soc_tracker.sv]
// Top level of the charge session state-of-charge tracker.
//
// Input channel (in_valid / in_stall) carries one beat per charger frame or
// update tick. Frame beats only update the latched charger values and give
// no result. Each tick beat gives exactly one result beat on the output
// channel (out_valid / out_stall).
// A tick updates the session state at the edge that accepts it. The next
// cycle loads the shared divider, which then gives one quotient bit a
// cycle; once it is done the sequencer moves to its final step, and the
// result register loads from there when the output is free. The input
// takes the next beat after the result register loads. A tick while the
// charger status is zero skips the divider; its all-zero result loads
// from the final step as well. A frame beat leaves the input free for the
// next beat.
// in_stall is high while a tick is in work. The result register holds its
// beat while the receiver stalls; a further tick may be accepted meanwhile
// and waits at its final step until the register is free.
// Configuration writes (write_enable, reg_index, write_data) take effect at
// once; reset loads the default limits and clears the session state.
module charge_session_soc_tracker import cssoc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  reg_index,
  input  logic [15:0] write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [10:0] frame_id,
  input  logic [31:0] frame_word0,
  input  logic [31:0] frame_word1,
  input  logic signed [15:0] rest_soc,
  input  logic [9:0]  battery_current_limit,
  input  logic [15:0] cell_max_mv,
  input  logic [9:0]  pack_voltage,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        session_active,
  output logic [13:0] soc_out,
  output logic [31:0] charge_added,
  output logic        charge_enable,
  output logic [7:0]  current_request,
  output logic [23:0] target_voltage_mv,
  output logic [9:0]  pack_voltage_out,
  output logic [7:0]  charger_max_out,
  output logic [7:0]  charger_current_out,
  output logic [15:0] charger_voltage_out,
  output logic [5:0]  charger_status_out
);

  state_t state, state_next;

  logic [7:0]  user_current_limit;
  logic [9:0]  capacity_ah;
  logic [15:0] idle_limit;

  logic [7:0]  charger_max_current;
  logic [15:0] charger_voltage;
  logic [7:0]  charger_current;
  logic [5:0]  charger_status;
  logic [13:0] base_soc;
  logic [31:0] charge_accum;
  logic [15:0] idle_ticks;
  logic        active_flag;

  // Per-tick values captured at accept.
  logic        zero_tick;
  logic [7:0]  req_hold;
  logic [23:0] target_hold;
  logic [9:0]  pack_hold;

  logic        in_accept;
  logic        tick_accept;
  logic        frame_accept;
  logic        div_start;
  logic        div_busy;
  logic [DIVD_W-1:0] div_quotient;
  logic        out_free;
  logic        result_load;

  logic [13:0] rest_clamped;
  logic [31:0] acc0, acc1, acc2;
  logic [15:0] idle0, idle1;
  logic [13:0] base_next;
  logic [32:0] acc_sum;
  logic [9:0]  req_min1;
  logic [7:0]  req_min;
  logic [9:0]  cap_eff;
  logic [DIVD_W-1:0] numer;
  logic [DIVS_W-1:0] denom;
  logic [DIVD_W:0]   soc_sum;
  logic [13:0] soc_val;

  assign in_stall     = (state != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign tick_accept  = in_accept && (opcode == OP_TICK);
  assign frame_accept = in_accept && (opcode == OP_FRAME);
  assign out_free     = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      user_current_limit <= 8'd255;
      capacity_ah        <= 10'd100;
      idle_limit         <= 16'd1800;
    end else if (write_enable) begin
      case (reg_index)
        REG_USER_LIMIT: user_current_limit <= write_data[7:0];
        REG_CAPACITY:   capacity_ah        <= write_data[9:0];
        REG_IDLE_LIMIT: idle_limit         <= write_data;
        default: ;
      endcase
    end
  end

  // Session update for one tick.
  always_comb begin
    if (rest_soc[15]) begin
      rest_clamped = '0;
    end else if (rest_soc[14:0] > {1'b0, SOC_FULL}) begin
      rest_clamped = SOC_FULL;
    end else begin
      rest_clamped = rest_soc[13:0];
    end

    base_next = active_flag ? base_soc : rest_clamped;
    acc0      = active_flag ? charge_accum : '0;
    idle0     = active_flag ? idle_ticks : '0;

    acc_sum = {1'b0, acc0} + 33'(charger_current);
    if (charger_current != '0) begin
      acc1  = acc_sum[32] ? '1 : acc_sum[31:0];
      idle1 = '0;
    end else begin
      acc1  = acc0;
      idle1 = (idle0 != 16'hFFFF) ? idle0 + 16'd1 : idle0;
    end

    acc2 = acc1;
    if (idle1 >= idle_limit) begin
      base_next = rest_clamped;
      acc2      = '0;
    end

    req_min1 = (battery_current_limit < {2'b0, user_current_limit}) ?
               battery_current_limit : {2'b0, user_current_limit};
    req_min  = ({2'b0, charger_max_current} < req_min1) ?
               charger_max_current : req_min1[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charger_max_current <= '0;
      charger_voltage     <= '0;
      charger_current     <= '0;
      charger_status      <= '0;
      base_soc            <= '0;
      charge_accum        <= '0;
      idle_ticks          <= '0;
      active_flag         <= 1'b0;
    end else if (frame_accept) begin
      if (frame_id == ID_MAX_CUR) begin
        charger_max_current <= frame_word0[31:24];
      end else if (frame_id == ID_STATUS) begin
        charger_voltage <= frame_word0[23:8];
        charger_current <= frame_word0[31:24];
        charger_status  <= frame_word1[13:8];
      end
    end else if (tick_accept) begin
      if (charger_status == '0) begin
        charge_accum <= '0;
        idle_ticks   <= '0;
        active_flag  <= 1'b0;
      end else begin
        base_soc     <= base_next;
        charge_accum <= acc2;
        idle_ticks   <= idle1;
        active_flag  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      zero_tick   <= (charger_status == '0);
      req_hold    <= req_min;
      target_hold <= 24'(NUM_CELLS) * 24'(cell_max_mv);
      pack_hold   <= pack_voltage;
    end
  end

  // Divider operands: charge times ten over capacity times 36.
  assign cap_eff   = (capacity_ah == '0) ? 10'd1 : capacity_ah;
  assign numer     = ({4'b0, charge_accum} << 3) + ({4'b0, charge_accum} << 1);
  assign denom     = ({6'b0, cap_eff} << 5) + ({6'b0, cap_eff} << 2);
  assign div_start = (state == ST_LOAD);

  cssoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (denom),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    soc_sum = {1'b0, div_quotient} + (DIVD_W+1)'(base_soc);
    soc_val = (soc_sum > (DIVD_W+1)'(SOC_FULL)) ? SOC_FULL : soc_sum[13:0];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    result_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (tick_accept) begin
          state_next = (charger_status == '0) ? ST_FINISH : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      if (zero_tick) begin
        session_active      <= 1'b0;
        soc_out             <= '0;
        charge_added        <= '0;
        charge_enable       <= 1'b0;
        current_request     <= '0;
        target_voltage_mv   <= '0;
        pack_voltage_out    <= '0;
        charger_max_out     <= '0;
        charger_current_out <= '0;
        charger_voltage_out <= '0;
        charger_status_out  <= '0;
      end else begin
        session_active      <= 1'b1;
        soc_out             <= soc_val;
        charge_added        <= charge_accum;
        charge_enable       <= (soc_val < SOC_FULL);
        current_request     <= req_hold;
        target_voltage_mv   <= target_hold;
        pack_voltage_out    <= pack_hold;
        charger_max_out     <= charger_max_current;
        charger_current_out <= charger_current;
        charger_voltage_out <= charger_voltage;
        charger_status_out  <= charger_status;
      end
    end
  end

endmodule
